### rtl/core/hkrb_pkg.sv
`timescale 1ns / 1ps

package hkrb_pkg;

    localparam int KEY_SLOTS_DEF  = 6;
    localparam int COUNT_BITS_DEF = 4;
    localparam int MOD_BITS       = 8;
    localparam int MOD_W          = $clog2(MOD_BITS);

    localparam logic [2:0] OP_PRESS_KEY    = 3'd0;
    localparam logic [2:0] OP_RELEASE_KEY  = 3'd1;
    localparam logic [2:0] OP_PRESS_MODS   = 3'd2;
    localparam logic [2:0] OP_RELEASE_MODS = 3'd3;
    localparam logic [2:0] OP_RELEASE_ALL  = 3'd4;
    localparam logic [2:0] OP_REPORT_SENT  = 3'd5;

    localparam logic [7:0]       RAW_BASE   = 8'd136;
    localparam logic [MOD_W-1:0] LSHIFT_BIT = MOD_W'(1);
    localparam int               SHIFT_FLAG = 7;

    localparam logic [7:0] ASCII_USAGE [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
    };

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] code;
    } t_in_word;

    typedef struct packed {
        logic       success;
        logic       report_pending;
        logic [7:0] modifier_bits;
        logic [7:0] slot_zero;
        logic [7:0] slot_one;
        logic [7:0] slot_two;
        logic [7:0] slot_three;
        logic [7:0] slot_four;
        logic [7:0] slot_five;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_FIND,
        S_FREE,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DECODE,
        CMD_MOD_STEP,
        CMD_FIND_STEP,
        CMD_FREE_STEP,
        CMD_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   last;
    } t_cmd;

    typedef struct packed {
        logic mod_map;
        logic scan;
        logic is_press;
        logic slot_match;
        logic slot_empty;
        logic out_free;
    } t_status;

endpackage

### rtl/core/hkrb_ctrl.sv
`timescale 1ns / 1ps

module hkrb_ctrl #(
    parameter int KEY_SLOTS = 6,
    parameter int IDX_W     = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hkrb_pkg::t_status i_status,
    output hkrb_pkg::t_cmd    o_cmd,
    output logic [IDX_W-1:0]  o_idx
);
    import hkrb_pkg::*;

    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(KEY_SLOTS - 1);
    localparam logic [IDX_W-1:0] MOD_LAST  = IDX_W'(MOD_BITS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_in_ready = 1'b0;
        o_cmd.op   = CMD_NONE;
        o_cmd.last = (r_idx == SLOT_LAST);
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.op = CMD_DECODE;
                n_idx    = '0;
                priority if (i_status.mod_map) n_state = S_MOD;
                else if (i_status.scan)        n_state = S_FIND;
                else                           n_state = S_DONE;
            end
            S_MOD: begin
                o_cmd.op = CMD_MOD_STEP;
                if (r_idx == MOD_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIND: begin
                o_cmd.op = CMD_FIND_STEP;
                priority if (i_status.slot_match) begin
                    n_state = S_DONE;
                end else if (r_idx == SLOT_LAST) begin
                    n_idx   = '0;
                    n_state = i_status.is_press ? S_FREE : S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FREE: begin
                o_cmd.op = CMD_FREE_STEP;
                if (i_status.slot_empty || r_idx == SLOT_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = CMD_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idx = r_idx;

endmodule

### rtl/core/hkrb_datapath.sv
`timescale 1ns / 1ps

module hkrb_datapath #(
    parameter int KEY_SLOTS  = 6,
    parameter int COUNT_BITS = 4,
    parameter int IDX_W      = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hkrb_pkg::t_in_word  i_in_word,
    input  hkrb_pkg::t_cmd      i_cmd,
    input  logic [IDX_W-1:0]    i_idx,
    output hkrb_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hkrb_pkg::t_out_word o_out_word
);
    import hkrb_pkg::*;

    localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

    logic [2:0]            r_op, n_op;
    logic [7:0]            r_code, n_code;
    logic [6:0]            r_usage, n_usage;
    logic [MOD_BITS-1:0]   r_mod, n_mod;
    logic [COUNT_BITS-1:0] r_mod_cnt [MOD_BITS];
    logic [COUNT_BITS-1:0] n_mod_cnt [MOD_BITS];
    logic [7:0]            r_slot [KEY_SLOTS];
    logic [7:0]            n_slot [KEY_SLOTS];
    logic [COUNT_BITS-1:0] r_slot_cnt [KEY_SLOTS];
    logic [COUNT_BITS-1:0] n_slot_cnt [KEY_SLOTS];
    logic                  r_pending, n_pending;
    logic                  r_success, n_success;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic [SLOT_W-1:0] slot_sel;
    logic              is_raw;
    logic              is_mod_code;
    logic [7:0]        tab;
    logic [6:0]        usage_dec;
    logic              unmapped;
    logic              key_op;
    logic              any_slot;
    logic              mod_en;
    logic              mod_press;
    logic [MOD_W-1:0]  mod_bit;
    logic [7:0]        slot_view [6];

    assign slot_sel    = i_idx[SLOT_W-1:0];
    assign is_raw      = (r_code >= RAW_BASE);
    assign is_mod_code = r_code[7] && !is_raw;
    assign tab         = ASCII_USAGE[r_code[6:0]];
    assign usage_dec   = is_raw ? 7'(r_code - RAW_BASE) : tab[6:0];
    assign unmapped    = !r_code[7] && (tab == 8'd0);
    assign key_op      = (r_op == OP_PRESS_KEY) || (r_op == OP_RELEASE_KEY);

    always_comb begin
        any_slot = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_slot[i] != 8'd0) any_slot = 1'b1;
        end
    end

    always_comb begin
        n_op       = r_op;
        n_code     = r_code;
        n_usage    = r_usage;
        n_mod      = r_mod;
        n_mod_cnt  = r_mod_cnt;
        n_slot     = r_slot;
        n_slot_cnt = r_slot_cnt;
        n_pending  = r_pending;
        n_success  = r_success;
        mod_en     = 1'b0;
        mod_press  = (r_op == OP_PRESS_KEY) || (r_op == OP_PRESS_MODS);
        mod_bit    = i_idx[MOD_W-1:0];

        unique case (i_cmd.op)
            CMD_LOAD: begin
                n_op   = i_in_word.opcode;
                n_code = i_in_word.code;
            end
            CMD_DECODE: begin
                n_success = 1'b1;
                unique case (r_op)
                    OP_PRESS_KEY, OP_RELEASE_KEY: begin
                        priority if (is_mod_code) begin
                            mod_en  = 1'b1;
                            mod_bit = r_code[MOD_W-1:0];
                        end else if (unmapped) begin
                            n_success = 1'b0;
                        end else begin
                            mod_en  = !is_raw && tab[SHIFT_FLAG];
                            mod_bit = LSHIFT_BIT;
                            n_usage = usage_dec;
                        end
                    end
                    OP_PRESS_MODS, OP_RELEASE_MODS: begin
                    end
                    OP_RELEASE_ALL: begin
                        n_mod      = '0;
                        n_mod_cnt  = '{default: '0};
                        n_slot     = '{default: '0};
                        n_slot_cnt = '{default: '0};
                        if (any_slot || r_mod != '0) n_pending = 1'b1;
                    end
                    OP_REPORT_SENT: begin
                        n_pending = 1'b0;
                    end
                    default: begin
                        n_success = 1'b0;
                    end
                endcase
            end
            CMD_MOD_STEP: begin
                mod_en = r_code[i_idx[MOD_W-1:0]];
            end
            CMD_FIND_STEP: begin
                if (r_slot[slot_sel] == {1'b0, r_usage}) begin
                    if (r_op == OP_PRESS_KEY) begin
                        if (r_slot_cnt[slot_sel] != '1) begin
                            n_slot_cnt[slot_sel] = r_slot_cnt[slot_sel] + 1'b1;
                        end
                    end else if (r_slot_cnt[slot_sel] != '0) begin
                        n_slot_cnt[slot_sel] = r_slot_cnt[slot_sel] - 1'b1;
                    end else begin
                        n_slot[slot_sel] = 8'd0;
                        n_pending        = 1'b1;
                    end
                end
            end
            CMD_FREE_STEP: begin
                if (r_slot[slot_sel] == 8'd0) begin
                    n_slot[slot_sel]     = {1'b0, r_usage};
                    n_slot_cnt[slot_sel] = '0;
                    n_pending            = 1'b1;
                end else if (i_cmd.last) begin
                    n_success = 1'b0;
                end
            end
            CMD_NONE, CMD_EMIT: begin
            end
            default: begin
            end
        endcase

        if (mod_en) begin
            if (mod_press) begin
                if (r_mod[mod_bit]) begin
                    if (r_mod_cnt[mod_bit] != '1) begin
                        n_mod_cnt[mod_bit] = r_mod_cnt[mod_bit] + 1'b1;
                    end
                end else begin
                    n_mod[mod_bit] = 1'b1;
                    n_pending      = 1'b1;
                end
            end else if (r_mod_cnt[mod_bit] != '0) begin
                n_mod_cnt[mod_bit] = r_mod_cnt[mod_bit] - 1'b1;
            end else if (r_mod[mod_bit]) begin
                n_mod[mod_bit] = 1'b0;
                n_pending      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod      <= '0;
            r_mod_cnt  <= '{default: '0};
            r_slot     <= '{default: '0};
            r_slot_cnt <= '{default: '0};
            r_pending  <= 1'b0;
        end else begin
            r_mod      <= n_mod;
            r_mod_cnt  <= n_mod_cnt;
            r_slot     <= n_slot;
            r_slot_cnt <= n_slot_cnt;
            r_pending  <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_code    <= n_code;
        r_usage   <= n_usage;
        r_success <= n_success;
    end

    for (genvar j = 0; j < 6; j++) begin : g_view
        if (j < KEY_SLOTS) begin : g_on
            assign slot_view[j] = r_slot[j];
        end else begin : g_off
            assign slot_view[j] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == CMD_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_EMIT) begin
            r_out.success        <= r_success;
            r_out.report_pending <= r_pending;
            r_out.modifier_bits  <= r_mod;
            r_out.slot_zero      <= slot_view[0];
            r_out.slot_one       <= slot_view[1];
            r_out.slot_two       <= slot_view[2];
            r_out.slot_three     <= slot_view[3];
            r_out.slot_four      <= slot_view[4];
            r_out.slot_five      <= slot_view[5];
        end
    end

    assign o_status.mod_map    = (r_op == OP_PRESS_MODS) || (r_op == OP_RELEASE_MODS);
    assign o_status.scan       = key_op && !is_mod_code && !unmapped && (usage_dec != 7'd0);
    assign o_status.is_press   = (r_op == OP_PRESS_KEY);
    assign o_status.slot_match = (r_slot[slot_sel] == {1'b0, r_usage});
    assign o_status.slot_empty = (r_slot[slot_sel] == 8'd0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/core/hid_keyboard_report_builder.sv
`timescale 1ns / 1ps

// Boot keyboard report keeper with six-key rollover and per-key repeat counts.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one command word:
// press or release a key code, press or release a modifier bitmap, release
// all, or report sent. Output channel (o_out_valid / i_out_ready /
// o_out_word) returns one word per command: success, pending flag, modifier
// byte and the first six key slots as they stand after the command.
// One command is in work at a time. After acceptance the command is decoded;
// release all, report sent, unmapped or modifier key codes then go straight
// to the output word. Modifier bitmaps step through the modifier bits,
// one modifier bit per cycle. Key codes scan the slots, one slot per cycle,
// first for a match and then, for a press with no match, for a free slot.
// The next command is taken from the cycle in which the output word turns valid.
// The output word sits in a register, so a stalled receiver does not block
// the next command; only the load of the following word waits for it.
// Reset clears the report, all counts, the pending flag and the output valid.

module hid_keyboard_report_builder #(
    parameter int KEY_SLOTS  = hkrb_pkg::KEY_SLOTS_DEF,
    parameter int COUNT_BITS = hkrb_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hkrb_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hkrb_pkg::t_out_word o_out_word
);
    import hkrb_pkg::*;

    localparam int IDX_W = $clog2((KEY_SLOTS > MOD_BITS) ? KEY_SLOTS : MOD_BITS);

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] idx;

    hkrb_ctrl #(
        .KEY_SLOTS (KEY_SLOTS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    hkrb_datapath #(
        .KEY_SLOTS  (KEY_SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
